// ----- hw/rtl/stnc_pkg.sv -----
`timescale 1ns / 1ps

package stnc_pkg;

   // scanner position within the source text
   typedef enum logic [2:0] {
      MODE_BETWEEN,
      MODE_COMMENT,
      MODE_WORD,
      MODE_WORD_ESC,
      MODE_STRING,
      MODE_STRING_ESC,
      MODE_IGNORE
   } scan_mode_type;

   localparam logic [3:0] KIND_PAREN   = 4'd0;
   localparam logic [3:0] KIND_BRACKET = 4'd1;
   localparam logic [3:0] KIND_BRACE   = 4'd2;
   localparam logic [3:0] KIND_CLOSE   = 4'd3;
   localparam logic [3:0] KIND_STRING  = 4'd4;
   localparam logic [3:0] KIND_HASH    = 4'd5;
   localparam logic [3:0] KIND_WORD    = 4'd6;
   localparam logic [3:0] KIND_ERROR   = 4'd7;
   localparam logic [3:0] KIND_END     = 4'd8;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_QUOTE      = 3'd1;
   localparam logic [2:0] ERR_EMPTY_HASH = 3'd2;
   localparam logic [2:0] ERR_MISMATCH   = 3'd3;
   localparam logic [2:0] ERR_UNCLOSED   = 3'd4;
   localparam logic [2:0] ERR_EXTRA      = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd6;

   localparam logic [1:0] BR_PAREN   = 2'd0;
   localparam logic [1:0] BR_BRACKET = 2'd1;
   localparam logic [1:0] BR_BRACE   = 2'd2;
   localparam logic [1:0] BR_NONE    = 2'd3;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam int MAX_RESULTS = 4;
   localparam int SLOT_W      = 2;
   localparam int COUNT_W     = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = 3;
   localparam int FIFO_LVL_W  = 4;
   localparam int CAND_COUNT  = 6;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [4:0]  nesting_depth;
      logic [2:0]  error_code;
      logic        run_last;
   } result_type;

   // all results caused by one byte, in order
   typedef struct packed {
      logic [COUNT_W-1:0]                 count;
      result_type [MAX_RESULTS-1:0]       slot;
   } batch_type;

   typedef struct packed {
      logic [FIFO_LVL_W-1:0] level;
      logic                  room;
   } fifo_status_type;

   function automatic result_type make_result(
      input logic [3:0]  kind,
      input logic [15:0] start,
      input logic [15:0] len,
      input logic [4:0]  depth,
      input logic [2:0]  err
   );
      result_type r;
      r.token_kind    = kind;
      r.token_start   = start;
      r.token_length  = len;
      r.nesting_depth = depth;
      r.error_code    = err;
      r.run_last      = 1'b0;
      return r;
   endfunction

endpackage

// ----- hw/rtl/stnc_scanner.sv -----
`timescale 1ns / 1ps

module stnc_scanner #(
   parameter int MAX_DEPTH     = 16,
   parameter int POSITION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          source_byte,
   input  logic                end_of_source,
   output stnc_pkg::batch_type batch
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int PB      = POSITION_BITS;

   stnc_pkg::scan_mode_type mode_ff, mode_in, mode1;
   logic                    qd_ff, qd_in, qd1;
   logic [PB-1:0]           pos_ff, pos_in;
   logic [PB-1:0]           ws_ff, ws_in, ws1;
   logic                    colon_ff, colon_in, colon1;
   logic [DEPTH_W-1:0]      depth_ff, depth_in, depth1;
   logic                    top_ff, top_in, top1;
   logic                    byp_ff, byp_in;
   logic [1:0]              byp_val_ff;
   logic [1:0]              rd_q_ff;
   logic [1:0]              stack_mem [MAX_DEPTH];
   logic [IDX_W-1:0]        rd_addr;
   logic [DEPTH_W-1:0]      depth_dec;

   logic                    push_en;
   logic                    w_valid, b_valid;
   stnc_pkg::result_type    w_res, b_res;

   logic                    is_sp, is_open, is_close, is_delim;
   logic [1:0]              open_br, close_br, stack_top;
   logic [PB-1:0]           endp;

   function automatic logic [15:0] to16(input logic [PB-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic logic [4:0] dep5(input logic [DEPTH_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[4:0];
   endfunction

   function automatic stnc_pkg::result_type mk(
      input logic [3:0]         kind,
      input logic [PB-1:0]      start,
      input logic [PB-1:0]      len,
      input logic [DEPTH_W-1:0] depth,
      input logic [2:0]         err
   );
      return stnc_pkg::make_result(kind, to16(start), to16(len), dep5(depth), err);
   endfunction

   function automatic stnc_pkg::result_type word_res(
      input logic [PB-1:0]      start,
      input logic [PB-1:0]      len,
      input logic               colon,
      input logic [DEPTH_W-1:0] depth
   );
      if (colon && len == PB'(1)) begin
         return mk(stnc_pkg::KIND_ERROR, start, len, depth, stnc_pkg::ERR_EMPTY_HASH);
      end
      return mk(colon ? stnc_pkg::KIND_HASH : stnc_pkg::KIND_WORD, start, len, depth,
                stnc_pkg::ERR_NONE);
   endfunction

   // byte classes
   always_comb begin
      unique case (source_byte)
         stnc_pkg::CH_LPAREN: open_br = stnc_pkg::BR_PAREN;
         stnc_pkg::CH_LBRACK: open_br = stnc_pkg::BR_BRACKET;
         stnc_pkg::CH_LBRACE: open_br = stnc_pkg::BR_BRACE;
         default:             open_br = stnc_pkg::BR_NONE;
      endcase
      unique case (source_byte)
         stnc_pkg::CH_RPAREN: close_br = stnc_pkg::BR_PAREN;
         stnc_pkg::CH_RBRACK: close_br = stnc_pkg::BR_BRACKET;
         stnc_pkg::CH_RBRACE: close_br = stnc_pkg::BR_BRACE;
         default:             close_br = stnc_pkg::BR_NONE;
      endcase
   end

   assign is_open  = (open_br != stnc_pkg::BR_NONE);
   assign is_close = (close_br != stnc_pkg::BR_NONE);
   assign is_sp    = (source_byte == stnc_pkg::CH_SPACE) || (source_byte == stnc_pkg::CH_TAB) ||
                     (source_byte == stnc_pkg::CH_LF) || (source_byte == stnc_pkg::CH_CR) ||
                     (source_byte == stnc_pkg::CH_COMMA);
   assign is_delim = is_sp || is_open || is_close || (source_byte == stnc_pkg::CH_SEMI);
   assign stack_top = byp_ff ? byp_val_ff : rd_q_ff;
   assign endp      = pos_ff + 1'b1;

   // effect of the byte itself
   always_comb begin
      logic run_between;
      mode1       = mode_ff;
      ws1         = ws_ff;
      colon1      = colon_ff;
      qd1         = qd_ff;
      depth1      = depth_ff;
      top1        = top_ff;
      push_en     = 1'b0;
      w_valid     = 1'b0;
      b_valid     = 1'b0;
      w_res       = '0;
      b_res       = '0;
      run_between = 1'b0;
      unique case (mode_ff)
         stnc_pkg::MODE_COMMENT: begin
            if (source_byte == stnc_pkg::CH_LF || source_byte == stnc_pkg::CH_CR) begin
               mode1 = stnc_pkg::MODE_BETWEEN;
            end
         end
         stnc_pkg::MODE_WORD: begin
            if (source_byte == stnc_pkg::CH_BSLASH) begin
               mode1 = stnc_pkg::MODE_WORD_ESC;
            end else if (is_delim) begin
               w_valid     = 1'b1;
               w_res       = word_res(ws_ff, pos_ff - ws_ff, colon_ff, depth_ff);
               top1        = top_ff | (depth_ff == '0);
               mode1       = stnc_pkg::MODE_BETWEEN;
               run_between = 1'b1;
            end
         end
         stnc_pkg::MODE_WORD_ESC: mode1 = stnc_pkg::MODE_WORD;
         stnc_pkg::MODE_STRING: begin
            if (source_byte == stnc_pkg::CH_BSLASH) begin
               mode1 = stnc_pkg::MODE_STRING_ESC;
            end else if (source_byte == (qd_ff ? stnc_pkg::CH_DQUOTE : stnc_pkg::CH_SQUOTE)) begin
               b_valid = 1'b1;
               b_res   = mk(stnc_pkg::KIND_STRING, ws_ff, pos_ff - ws_ff + 1'b1, depth_ff,
                            stnc_pkg::ERR_NONE);
               top1    = top_ff | (depth_ff == '0);
               mode1   = stnc_pkg::MODE_BETWEEN;
            end
         end
         stnc_pkg::MODE_STRING_ESC: mode1 = stnc_pkg::MODE_STRING;
         stnc_pkg::MODE_IGNORE: ;
         default: run_between = 1'b1;
      endcase

      if (run_between && !is_sp) begin
         if (source_byte == stnc_pkg::CH_SEMI) begin
            mode1 = stnc_pkg::MODE_COMMENT;
         end else if (top1) begin
            mode1 = stnc_pkg::MODE_IGNORE;
            ws1   = pos_ff;
         end else if (is_open) begin
            b_valid = 1'b1;
            if (depth_ff >= DEPTH_W'(MAX_DEPTH)) begin
               b_res = mk(stnc_pkg::KIND_ERROR, pos_ff, PB'(1), depth_ff, stnc_pkg::ERR_OVERFLOW);
            end else begin
               push_en = 1'b1;
               depth1  = depth_ff + 1'b1;
               b_res   = mk({2'b00, open_br}, pos_ff, PB'(1), depth1, stnc_pkg::ERR_NONE);
            end
         end else if (is_close) begin
            b_valid = 1'b1;
            if (depth_ff == '0 || stack_top != close_br) begin
               b_res = mk(stnc_pkg::KIND_ERROR, pos_ff, PB'(1), depth_ff, stnc_pkg::ERR_MISMATCH);
            end else begin
               depth1 = depth_ff - 1'b1;
               b_res  = mk(stnc_pkg::KIND_CLOSE, pos_ff, PB'(1), depth1, stnc_pkg::ERR_NONE);
            end
            top1 = top1 | (depth1 == '0);
         end else begin
            ws1 = pos_ff;
            if (source_byte == stnc_pkg::CH_DQUOTE || source_byte == stnc_pkg::CH_SQUOTE) begin
               mode1 = stnc_pkg::MODE_STRING;
               qd1   = (source_byte == stnc_pkg::CH_DQUOTE);
            end else if (source_byte == stnc_pkg::CH_BSLASH) begin
               mode1  = stnc_pkg::MODE_WORD_ESC;
               colon1 = 1'b0;
            end else begin
               mode1  = stnc_pkg::MODE_WORD;
               colon1 = (source_byte == stnc_pkg::CH_COLON);
            end
         end
      end
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      qd_in    = qd_ff;
      pos_in   = pos_ff;
      ws_in    = ws_ff;
      colon_in = colon_ff;
      depth_in = depth_ff;
      top_in   = top_ff;
      if (accept) begin
         if (end_of_source) begin
            mode_in  = stnc_pkg::MODE_BETWEEN;
            qd_in    = 1'b0;
            pos_in   = '0;
            ws_in    = '0;
            colon_in = 1'b0;
            depth_in = '0;
            top_in   = 1'b0;
         end else begin
            mode_in  = mode1;
            qd_in    = qd1;
            pos_in   = endp;
            ws_in    = ws1;
            colon_in = colon1;
            depth_in = depth1;
            top_in   = top1;
         end
      end
      byp_in    = accept && push_en;
      depth_dec = depth_in - 1'b1;
      rd_addr   = depth_dec[IDX_W-1:0];
   end

   // results
   always_comb begin
      stnc_pkg::result_type                cand [stnc_pkg::CAND_COUNT];
      logic [stnc_pkg::CAND_COUNT-1:0]     cvalid;
      logic [stnc_pkg::COUNT_W-1:0]        n;
      logic [PB-1:0]                       elen;
      stnc_pkg::batch_type                 bt;
      elen      = endp - ws1;
      cand[0]   = w_res;
      cvalid[0] = w_valid;
      cand[1]   = b_res;
      cvalid[1] = b_valid;
      cand[2]   = '0;
      cvalid[2] = 1'b0;
      if (mode1 == stnc_pkg::MODE_WORD || mode1 == stnc_pkg::MODE_WORD_ESC) begin
         cand[2]   = word_res(ws1, elen, colon1, depth1);
         cvalid[2] = end_of_source;
      end else if (mode1 == stnc_pkg::MODE_STRING || mode1 == stnc_pkg::MODE_STRING_ESC) begin
         cand[2]   = mk(stnc_pkg::KIND_ERROR, ws1, elen, depth1, stnc_pkg::ERR_QUOTE);
         cvalid[2] = end_of_source;
      end
      cand[3]   = mk(stnc_pkg::KIND_ERROR, endp, '0, depth1, stnc_pkg::ERR_UNCLOSED);
      cvalid[3] = end_of_source && (depth1 != '0);
      cand[4]   = mk(stnc_pkg::KIND_ERROR, ws1, elen, depth1, stnc_pkg::ERR_EXTRA);
      cvalid[4] = end_of_source && (mode1 == stnc_pkg::MODE_IGNORE);
      cand[5]   = mk(stnc_pkg::KIND_END, endp, '0, '0, stnc_pkg::ERR_NONE);
      cvalid[5] = end_of_source;

      bt = '0;
      n  = '0;
      for (int i = 0; i < stnc_pkg::CAND_COUNT; i++) begin
         if (cvalid[i]) begin
            if (n < stnc_pkg::COUNT_W'(stnc_pkg::MAX_RESULTS)) begin
               bt.slot[n[stnc_pkg::SLOT_W-1:0]] = cand[i];
            end
            n = n + 1'b1;
         end
      end
      if (n != '0) begin
         bt.slot[stnc_pkg::SLOT_W'(n - 1'b1)].run_last = 1'b1;
      end
      bt.count = n;
      batch    = bt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stnc_pkg::MODE_BETWEEN;
         qd_ff    <= 1'b0;
         pos_ff   <= '0;
         ws_ff    <= '0;
         colon_ff <= 1'b0;
         depth_ff <= '0;
         top_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         qd_ff    <= qd_in;
         pos_ff   <= pos_in;
         ws_ff    <= ws_in;
         colon_ff <= colon_in;
         depth_ff <= depth_in;
         top_ff   <= top_in;
         byp_ff   <= byp_in;
      end
   end

   // bracket stack: top entry read ahead into a register from the next depth, fresh push forwarded
   always_ff @(posedge clock) begin
      if (accept && push_en) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= open_br;
      end
      rd_q_ff    <= stack_mem[rd_addr];
      byp_val_ff <= open_br;
   end

endmodule

// ----- hw/rtl/stnc_result_fifo.sv -----
`timescale 1ns / 1ps

module stnc_result_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  stnc_pkg::batch_type       batch,
   output stnc_pkg::result_type      head,
   output logic                      head_valid,
   input  logic                      head_ready,
   output stnc_pkg::fifo_status_type status
);

   stnc_pkg::result_type                   mem [stnc_pkg::FIFO_DEPTH];
   logic [stnc_pkg::FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [stnc_pkg::FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [stnc_pkg::FIFO_LVL_W-1:0]        level_ff, level_in;
   logic [stnc_pkg::COUNT_W-1:0]           n_push;
   logic                                   pop;

   assign n_push     = push ? batch.count : '0;
   assign head_valid = (level_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign pop        = head_valid && head_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + stnc_pkg::FIFO_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + stnc_pkg::FIFO_PTR_W'(pop);
      level_in  = level_ff + stnc_pkg::FIFO_LVL_W'(n_push) - stnc_pkg::FIFO_LVL_W'(pop);
   end

   assign status.level = level_ff;
   assign status.room  = (level_ff <= stnc_pkg::FIFO_LVL_W'(stnc_pkg::FIFO_DEPTH -
                                                            stnc_pkg::MAX_RESULTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < stnc_pkg::MAX_RESULTS; k++) begin
         if (stnc_pkg::COUNT_W'(k) < n_push) begin
            mem[wr_ptr_ff + stnc_pkg::FIFO_PTR_W'(k)] <= batch.slot[k];
         end
      end
   end

endmodule

// ----- hw/rtl/script_tokenizer_nesting_checker_top.sv -----
`timescale 1ns / 1ps

// Script tokenizer and bracket nesting checker. One source byte is taken per
// transfer on req_, with req_tlast set on the final byte of the source; each byte
// is decoded in the cycle it is taken and its results (none, one or two, up to
// four on the final byte) land in an 8-entry result queue that rsp_ drains at one
// transfer per cycle while rsp_tready is high, rsp_tlast marking the last result
// of a byte. Input is accepted every cycle while the queue holds four results or
// fewer, so the sustained rate is one byte per cycle as long as bytes average no
// more than one result each; the queue drain rate sets the limit otherwise. The
// bracket stack is MAX_DEPTH entries with a read-ahead of the top entry and needs
// no clearing after reset.

module script_tokenizer_nesting_checker_top #(
   parameter int MAX_DEPTH     = 16,
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   input  logic        req_tlast,   // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // token_start, token_length, nesting_depth, error_code
   output logic [3:0]  rsp_tuser,   // token_kind
   output logic        rsp_tlast    // run_last
);

   stnc_pkg::batch_type       batch;
   stnc_pkg::result_type      head;
   stnc_pkg::fifo_status_type fifo_status;
   logic                      accept;

   assign req_tready = fifo_status.room;
   assign accept     = req_tvalid && req_tready;

   stnc_scanner #(
      .MAX_DEPTH     (MAX_DEPTH),
      .POSITION_BITS (POSITION_BITS)
   ) u_scanner (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .source_byte   (req_tdata),
      .end_of_source (req_tlast),
      .batch         (batch)
   );

   stnc_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .batch      (batch),
      .head       (head),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .status     (fifo_status)
   );

   assign rsp_tdata = {head.error_code, head.nesting_depth, head.token_length, head.token_start};
   assign rsp_tuser = head.token_kind;
   assign rsp_tlast = head.run_last;

   a_end_closes_source : assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |-> batch.count != '0 &&
      batch.slot[stnc_pkg::SLOT_W'(batch.count - 1'b1)].token_kind == stnc_pkg::KIND_END)
      else $error("final byte did not end with an end result");

   a_mid_byte_results : assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast |-> batch.count <= stnc_pkg::COUNT_W'(2))
      else $error("ordinary byte produced more than two results");

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= stnc_pkg::FIFO_LVL_W'(stnc_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

endmodule
